// ===== hdl/ppp_pkg.sv =====
// Shared types and constants for the particle pool physics core.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

    localparam logic [31:0] LFSR_MASK     = 32'h8020_0003;
    localparam logic [14:0] GRAVITY_RST   = 15'd2560;
    localparam logic [7:0]  BOUNCE_RST    = 8'd102;
    localparam logic [15:0] VY_SPAWN_BASE = 16'd1792;
    localparam logic [14:0] SIZE_OFFSET   = 15'd9010;
    localparam logic [15:0] LIFE_OFFSET   = 16'd25650;
    // floor(n/100) == (n * DIV100_MUL) >> 24 for n < 2^16
    localparam logic [17:0] DIV100_MUL    = 18'd167773;
    // floor(n/5) == (n * DIV5_MUL) >> 20 for n < 2^18
    localparam logic [17:0] DIV5_MUL      = 18'd209716;
    localparam logic [17:0] DIV5_BIAS     = 18'd100000;
    localparam logic [15:0] DIV5_UNBIAS   = 16'd20000;

    localparam logic [1:0] CFG_GRAVITY = 2'd0;
    localparam logic [1:0] CFG_BOUNCE  = 2'd1;
    localparam logic [1:0] CFG_SEED    = 2'd2;

    localparam logic OP_SPAWN = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] KIND_SPAWN = 2'd0;
    localparam logic [1:0] KIND_STATE = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SP_SCAN, ST_SP_VX, ST_SP_VY, ST_SP_VZ, ST_SP_SZ, ST_SP_LF, ST_SP_WR,
        ST_SP_REPORT,
        ST_TK_SCAN, ST_TK_LD, ST_TK_GRAV, ST_TK_PX, ST_TK_PY, ST_TK_PZ,
        ST_TK_BY, ST_TK_BX, ST_TK_BZ, ST_TK_DEC, ST_TK_WB, ST_TK_EMIT, ST_TK_FIN
    } t_state;

    typedef enum logic [4:0] {
        DP_NONE, DP_LOAD, DP_SKIP,
        DP_DRAW_VX, DP_DRAW_VY, DP_DRAW_VZ, DP_DRAW_SZ, DP_DRAW_LF, DP_SP_WR,
        DP_REPORT,
        DP_RD, DP_LD, DP_GRAV, DP_PX, DP_PY, DP_PZ, DP_BY, DP_BX, DP_BZ,
        DP_DEC, DP_WB, DP_EMIT, DP_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_end;
        logic slot_act;
        logic want_met;
        logic out_free;
        logic pend_valid;
        logic dead;
    } t_dp_status;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [15:0] size;
        logic signed [15:0] life;
    } t_slot_rec;

    function automatic logic signed [15:0] f_sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ppp_ctrl.sv =====
// Sequencer for the particle pool core: walks the slots and issues at most one
// datapath command per cycle, holding while the output is stalled. Depends on ppp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppp_ctrl
    import ppp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_op,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_op == OP_SPAWN) ? ST_SP_SCAN : ST_TK_SCAN;
                end
            end
            ST_SP_SCAN: begin
                if (i_status.idx_end || i_status.want_met) begin
                    n_state = ST_SP_REPORT;
                end else if (!i_status.slot_act) begin
                    n_state = ST_SP_VX;
                end
            end
            ST_SP_VX:     n_state = ST_SP_VY;
            ST_SP_VY:     n_state = ST_SP_VZ;
            ST_SP_VZ:     n_state = ST_SP_SZ;
            ST_SP_SZ:     n_state = ST_SP_LF;
            ST_SP_LF:     n_state = ST_SP_WR;
            ST_SP_WR:     n_state = ST_SP_SCAN;
            ST_SP_REPORT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            ST_TK_SCAN: begin
                if (i_status.idx_end) begin
                    n_state = ST_TK_FIN;
                end else if (i_status.slot_act) begin
                    n_state = ST_TK_LD;
                end
            end
            ST_TK_LD:   n_state = ST_TK_GRAV;
            ST_TK_GRAV: n_state = ST_TK_PX;
            ST_TK_PX:   n_state = ST_TK_PY;
            ST_TK_PY:   n_state = ST_TK_PZ;
            ST_TK_PZ:   n_state = ST_TK_BY;
            ST_TK_BY:   n_state = ST_TK_BX;
            ST_TK_BX:   n_state = ST_TK_BZ;
            ST_TK_BZ:   n_state = ST_TK_DEC;
            ST_TK_DEC:  n_state = ST_TK_WB;
            ST_TK_WB:   n_state = i_status.dead ? ST_TK_SCAN : ST_TK_EMIT;
            ST_TK_EMIT: begin
                if (!i_status.pend_valid || i_status.out_free) n_state = ST_TK_SCAN;
            end
            ST_TK_FIN: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        o_cmd.op   = DP_NONE;
        unique case (r_state)
            ST_IDLE:    if (i_in_valid) o_cmd.op = DP_LOAD;
            ST_SP_SCAN: begin
                if (!i_status.idx_end && !i_status.want_met && i_status.slot_act) begin
                    o_cmd.op = DP_SKIP;
                end
            end
            ST_SP_VX:     o_cmd.op = DP_DRAW_VX;
            ST_SP_VY:     o_cmd.op = DP_DRAW_VY;
            ST_SP_VZ:     o_cmd.op = DP_DRAW_VZ;
            ST_SP_SZ:     o_cmd.op = DP_DRAW_SZ;
            ST_SP_LF:     o_cmd.op = DP_DRAW_LF;
            ST_SP_WR:     o_cmd.op = DP_SP_WR;
            ST_SP_REPORT: if (i_status.out_free) o_cmd.op = DP_REPORT;
            ST_TK_SCAN: begin
                if (!i_status.idx_end) begin
                    o_cmd.op = i_status.slot_act ? DP_RD : DP_SKIP;
                end
            end
            ST_TK_LD:   o_cmd.op = DP_LD;
            ST_TK_GRAV: o_cmd.op = DP_GRAV;
            ST_TK_PX:   o_cmd.op = DP_PX;
            ST_TK_PY:   o_cmd.op = DP_PY;
            ST_TK_PZ:   o_cmd.op = DP_PZ;
            ST_TK_BY:   o_cmd.op = DP_BY;
            ST_TK_BX:   o_cmd.op = DP_BX;
            ST_TK_BZ:   o_cmd.op = DP_BZ;
            ST_TK_DEC:  o_cmd.op = DP_DEC;
            ST_TK_WB:   o_cmd.op = DP_WB;
            ST_TK_EMIT: begin
                if (!i_status.pend_valid || i_status.out_free) o_cmd.op = DP_EMIT;
            end
            ST_TK_FIN:  if (i_status.out_free) o_cmd.op = DP_FIN;
            default:    o_cmd.op = DP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/ppp_dp.sv =====
// Datapath of the particle pool core: slot memory, active bits, LFSR,
// shared multiplier arithmetic and the output register. Depends on ppp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppp_dp
    import ppp_pkg::*;
#(
    parameter int POOL_SIZE = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  wire               i_cfg_we,
    input  wire        [1:0]  i_cfg_idx,
    input  wire        [31:0] i_cfg_data,
    input  wire signed [15:0] i_origin_x,
    input  wire signed [15:0] i_origin_y,
    input  wire signed [15:0] i_origin_z,
    input  wire        [6:0]  i_burst_count,
    input  wire        [15:0] i_tick_dt,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic       [1:0]  o_kind,
    output logic       [5:0]  o_slot,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic       [14:0] o_particle_size,
    output logic       [6:0]  o_spawned_count,
    output logic              o_last
);

    localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);

    // configuration and random source
    logic [14:0] r_gravity;
    logic [7:0]  r_bounce;
    logic [31:0] r_lfsr;

    // item context
    logic [15:0]        r_dt;
    logic [14:0]        r_gstep;
    logic signed [15:0] r_ox, r_oy, r_oz;
    logic [6:0]         r_want, r_done;
    logic [CW-1:0]      r_idx;
    logic [POOL_SIZE-1:0] r_active;

    // slot memory
    t_slot_rec r_mem [POOL_SIZE];
    t_slot_rec r_rd;
    t_slot_rec w_wdata;
    logic      w_we;

    // working slot
    logic signed [15:0] r_px, r_py, r_pz, r_vx, r_vy, r_vz, r_size, r_life;
    logic [14:0]        r_num_size;
    logic [15:0]        r_num_life;
    logic               r_bounced;
    logic               r_dead;

    // held result of a tick, sent once the next one (or the end) is known
    logic               r_pend_valid;
    logic [5:0]         r_pend_slot;
    logic signed [15:0] r_pend_x, r_pend_y, r_pend_z;
    logic [14:0]        r_pend_size;

    logic w_out_free;
    assign w_out_free = !o_out_valid || !i_out_stall;

    // load a new result beat into the output register
    logic w_out_set;
    assign w_out_set = (i_cmd.op == DP_EMIT && r_pend_valid) ||
                       (i_cmd.op == DP_REPORT) || (i_cmd.op == DP_FIN);

    assign o_status.idx_end    = (r_idx == CW'(POOL_SIZE));
    assign o_status.slot_act   = r_active[r_idx[IW-1:0]];
    assign o_status.want_met   = (r_done >= r_want);
    assign o_status.out_free   = w_out_free;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.dead       = r_dead;

    // LFSR step and draw
    logic [31:0]        w_lfsr_nx;
    logic [8:0]         w_u;
    logic signed [9:0]  w_r;
    assign w_lfsr_nx = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_MASK : 32'd0);
    assign w_u       = w_lfsr_nx[8:0];
    assign w_r       = $signed({1'b0, w_u}) - 10'sd256;

    logic signed [15:0] w_vx_draw, w_vy_draw;
    assign w_vx_draw = 16'(w_r) * 16'sd6;
    assign w_vy_draw = $signed(VY_SPAWN_BASE) + 16'(w_r) * 16'sd3;

    // divide-by-100 for size and life
    logic [33:0] w_size_prod, w_life_prod;
    logic signed [15:0] w_size_calc, w_life_calc;
    assign w_size_prod = {19'd0, r_num_size} * {16'd0, DIV100_MUL};
    assign w_life_prod = {18'd0, r_num_life} * {16'd0, DIV100_MUL};
    assign w_size_calc = $signed({6'd0, w_size_prod[33:24]});
    assign w_life_calc = $signed({6'd0, w_life_prod[33:24]});

    // motion multiplier, shared over the three axes
    logic signed [15:0] w_mv_v, w_mv_p;
    logic signed [32:0] w_mv_prod;
    logic signed [17:0] w_mv_sum;
    always_comb begin
        unique case (i_cmd.op)
            DP_PX:   begin w_mv_v = r_vx; w_mv_p = r_px; end
            DP_PY:   begin w_mv_v = r_vy; w_mv_p = r_py; end
            default: begin w_mv_v = r_vz; w_mv_p = r_pz; end
        endcase
    end
    assign w_mv_prod = 33'(w_mv_v) * $signed({17'd0, r_dt});
    assign w_mv_sum  = 18'(w_mv_p) + 18'($signed(w_mv_prod[32:16]));

    // bounce on vertical velocity
    logic signed [16:0] w_neg_vy;
    logic signed [25:0] w_by_prod;
    assign w_neg_vy  = -17'(r_vy);
    assign w_by_prod = 26'(w_neg_vy) * $signed({18'd0, r_bounce});

    // floor(3v/5) on horizontal velocity via biased reciprocal multiply
    logic signed [15:0] w_h_v;
    logic [17:0]        w_h_biased;
    logic [35:0]        w_h_prod;
    logic signed [15:0] w_h_res;
    assign w_h_v      = (i_cmd.op == DP_BX) ? r_vx : r_vz;
    assign w_h_biased = 18'(18'(w_h_v) * 18'sd3) + DIV5_BIAS;
    assign w_h_prod   = w_h_biased * DIV5_MUL;
    assign w_h_res    = $signed(w_h_prod[35:20]) - $signed(DIV5_UNBIAS);

    // decay
    logic [16:0] w_dt_l, w_dt_s;
    logic signed [17:0] w_life_nx, w_size_nx;
    assign w_dt_l    = {1'b0, r_dt} + 17'd128;
    assign w_dt_s    = {1'b0, r_dt} + 17'd512;
    assign w_life_nx = 18'(r_life) - {9'd0, w_dt_l[16:8]};
    assign w_size_nx = 18'(r_size) - {11'd0, w_dt_s[16:10]};

    logic [30:0] w_gprod;
    assign w_gprod = {16'd0, r_gravity} * {15'd0, i_tick_dt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RST;
            r_bounce  <= BOUNCE_RST;
            r_lfsr    <= 32'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRAVITY: r_gravity <= i_cfg_data[14:0];
                CFG_BOUNCE:  r_bounce  <= i_cfg_data[7:0];
                CFG_SEED:    r_lfsr    <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                default: ;
            endcase
        end else if (i_cmd.op == DP_DRAW_VX || i_cmd.op == DP_DRAW_VY ||
                     i_cmd.op == DP_DRAW_VZ || i_cmd.op == DP_DRAW_SZ ||
                     i_cmd.op == DP_DRAW_LF) begin
            r_lfsr <= w_lfsr_nx;
        end
    end

    always_comb begin
        w_we    = (i_cmd.op == DP_SP_WR) || (i_cmd.op == DP_WB);
        w_wdata = '{px: r_px, py: r_py, pz: r_pz, vx: r_vx, vy: r_vy, vz: r_vz,
                    size: r_size, life: r_life};
        if (i_cmd.op == DP_SP_WR) w_wdata.life = w_life_calc;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[r_idx[IW-1:0]] <= w_wdata;
        if (i_cmd.op == DP_RD) r_rd <= r_mem[r_idx[IW-1:0]];
    end

    // control state: counters, active bits, pending and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_idx        <= '0;
            r_done       <= '0;
            r_pend_valid <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (w_out_set) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                DP_LOAD: begin
                    r_idx        <= '0;
                    r_done       <= '0;
                    r_pend_valid <= 1'b0;
                end
                DP_SKIP: r_idx <= r_idx + 1'b1;
                DP_SP_WR: begin
                    r_active[r_idx[IW-1:0]] <= 1'b1;
                    r_done <= r_done + 7'd1;
                    r_idx  <= r_idx + 1'b1;
                end
                DP_WB: begin
                    if (r_dead) begin
                        r_active[r_idx[IW-1:0]] <= 1'b0;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                DP_EMIT: begin
                    r_pend_valid <= 1'b1;
                    r_idx        <= r_idx + 1'b1;
                end
                DP_REPORT, DP_FIN: begin
                    r_pend_valid <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_dt    <= i_tick_dt;
                r_gstep <= w_gprod[30:16];
                r_ox    <= i_origin_x;
                r_oy    <= i_origin_y;
                r_oz    <= i_origin_z;
                r_want  <= i_burst_count;
            end
            DP_DRAW_VX: begin
                r_px <= r_ox;
                r_py <= r_oy;
                r_pz <= r_oz;
                r_vx <= w_vx_draw;
            end
            DP_DRAW_VY: r_vy <= w_vy_draw;
            DP_DRAW_VZ: r_vz <= w_vx_draw;
            DP_DRAW_SZ: r_num_size <= 15'(w_u) * 15'd15 + SIZE_OFFSET;
            DP_DRAW_LF: begin
                r_num_life <= 16'(w_u) * 16'd40 + LIFE_OFFSET;
                r_size     <= w_size_calc;
            end
            DP_LD: begin
                r_px   <= r_rd.px;
                r_py   <= r_rd.py;
                r_pz   <= r_rd.pz;
                r_vx   <= r_rd.vx;
                r_vy   <= r_rd.vy;
                r_vz   <= r_rd.vz;
                r_size <= r_rd.size;
                r_life <= r_rd.life;
            end
            DP_GRAV: r_vy <= f_sat16(18'(r_vy) - {3'd0, r_gstep});
            DP_PX:   r_px <= f_sat16(w_mv_sum);
            DP_PY:   r_py <= f_sat16(w_mv_sum);
            DP_PZ:   r_pz <= f_sat16(w_mv_sum);
            DP_BY: begin
                r_bounced <= r_py[15];
                if (r_py[15]) begin
                    r_py <= '0;
                    r_vy <= f_sat16(w_by_prod[25:8]);
                end
            end
            DP_BX: if (r_bounced) r_vx <= w_h_res;
            DP_BZ: if (r_bounced) r_vz <= w_h_res;
            DP_DEC: begin
                r_life <= f_sat16(w_life_nx);
                r_size <= f_sat16(w_size_nx);
                r_dead <= (f_sat16(w_life_nx) <= 16'sd0) || (f_sat16(w_size_nx) <= 16'sd0);
            end
            DP_EMIT: begin
                if (r_pend_valid) begin
                    o_kind          <= KIND_STATE;
                    o_slot          <= r_pend_slot;
                    o_pos_x         <= r_pend_x;
                    o_pos_y         <= r_pend_y;
                    o_pos_z         <= r_pend_z;
                    o_particle_size <= r_pend_size;
                    o_spawned_count <= '0;
                    o_last          <= 1'b0;
                end
                r_pend_slot <= 6'(r_idx);
                r_pend_x    <= r_px;
                r_pend_y    <= r_py;
                r_pend_z    <= r_pz;
                r_pend_size <= r_size[14:0];
            end
            DP_FIN: begin
                o_kind          <= r_pend_valid ? KIND_STATE : KIND_EMPTY;
                o_slot          <= r_pend_valid ? r_pend_slot : 6'd0;
                o_pos_x         <= r_pend_valid ? r_pend_x : 16'sd0;
                o_pos_y         <= r_pend_valid ? r_pend_y : 16'sd0;
                o_pos_z         <= r_pend_valid ? r_pend_z : 16'sd0;
                o_particle_size <= r_pend_valid ? r_pend_size : 15'd0;
                o_spawned_count <= '0;
                o_last          <= 1'b1;
            end
            DP_REPORT: begin
                o_kind          <= KIND_SPAWN;
                o_slot          <= '0;
                o_pos_x         <= '0;
                o_pos_y         <= '0;
                o_pos_z         <= '0;
                o_particle_size <= '0;
                o_spawned_count <= r_done;
                o_last          <= 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/particle_pool_physics_core.sv =====
// Particle pool physics core: spawn bursts and timed updates over a pool of
// debris slots, built from ppp_ctrl (sequencer) and ppp_dp (datapath).
// One item at a time. A spawn scans slots until the burst is met or the pool ends,
// filling each free slot; a tick walks all POOL_SIZE slots, updating each active slot
// and sending each survivor. A new beat is taken the cycle after the last result.
// Reset (synchronous, active low): all slots inactive, registers to defaults, LFSR to 1.
`timescale 1ns / 1ps
`default_nettype none

module particle_pool_physics_core
    import ppp_pkg::*;
#(
    parameter int POOL_SIZE = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // configuration writes, taken at any edge with i_cfg_we high outside reset
    input  wire               i_cfg_we,
    input  wire        [1:0]  i_cfg_idx,
    input  wire        [31:0] i_cfg_data,
    // input beats
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire               i_op,
    input  wire signed [15:0] i_origin_x,
    input  wire signed [15:0] i_origin_y,
    input  wire signed [15:0] i_origin_z,
    input  wire        [6:0]  i_burst_count,
    input  wire        [15:0] i_tick_dt,
    // result beats
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic       [1:0]  o_kind,
    output logic       [5:0]  o_slot,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic       [14:0] o_particle_size,
    output logic       [6:0]  o_spawned_count,
    output logic              o_last
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer: idle until a beat arrives, then walk the pool one slot at a
    // time, handing each step to the datapath.
    ppp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: slot memory, active bits, LFSR and result register. A tick
    // result is held back one slot so the final beat can carry last.
    ppp_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_origin_z      (i_origin_z),
        .i_burst_count   (i_burst_count),
        .i_tick_dt       (i_tick_dt),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_slot          (o_slot),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_particle_size (o_particle_size),
        .o_spawned_count (o_spawned_count),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire
